FILE: design/htle_pkg.sv
// Shared types, constants and the quarter-wave sine table for the tide block.
// No dependencies; the top level, htle_ctrl and htle_datapath import this package.
package htle_pkg;

  localparam int NUM_TERMS       = 5;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TERM_REGS       = 5;
  localparam int ACT_TERMS       = (NUM_TERMS < TERM_REGS) ? NUM_TERMS : TERM_REGS;

  localparam int TAB_N      = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_W = SINE_TABLE_BITS + 1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int TERM_IDX_W = $clog2(TERM_REGS);
  localparam int REG_IDX_W  = $clog2(TERM_REGS + 1);
  localparam int CNT_W      = $clog2(TERM_REGS + 3);
  // last cycle of the term pipeline: the last constituent reaches the accumulator
  localparam int CALC_LAST  = ACT_TERMS + 2;
  localparam int ACC_W      = 20;
  localparam int CFG_W      = 64;

  localparam logic [REG_IDX_W-1:0] REG_MEAN  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TERM0 = REG_IDX_W'(1);

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MAX  = 2'd1;
  localparam logic [1:0] KIND_MIN  = 2'd2;

  localparam logic signed [15:0] MEAN_RESET = 16'sd2048;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                  start;
    logic                  issue;
    logic [TERM_IDX_W-1:0] term_idx;
    logic                  finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef logic [14:0] sine_tab_t [0:TAB_N];

  // Quarter-wave Q1.15 table, Taylor series evaluated in Q2.30 at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    logic [63:0]       x;
    logic [63:0]       term;
    logic [63:0]       q;
    logic signed [63:0] sum;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      q = ($unsigned(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[k] = q[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: design/htle_if.sv
// Valid/ready stream interfaces for sample beats and result beats.
// Depends on nothing; used by the top level.
interface htle_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;
  logic        restart;

  modport source (output valid, output sample_time, output restart, input ready);
  modport sink   (input valid, input sample_time, input restart, output ready);
endinterface

interface htle_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tide_level;
  logic [1:0]         extremum_kind;
  logic [31:0]        extremum_time;
  logic signed [15:0] extremum_level;
  logic               extremum_high;

  modport source (output valid, output tide_level, output extremum_kind,
                  output extremum_time, output extremum_level, output extremum_high,
                  input ready);
  modport sink   (input valid, input tide_level, input extremum_kind,
                  input extremum_time, input extremum_level, input extremum_high,
                  output ready);
endinterface

FILE: design/harmonic_tide_level_extrema.sv
// Harmonic tide level with local high/low detection.
//
// samples: valid/ready beat carrying sample_time (Q22.10 hours) and restart.
// levels:  valid/ready beat carrying the saturated Q4.12 level of that
//          sample and, for the sample before it, whether it was a strict
//          local maximum or minimum, its time, level and whether it lies
//          above the mean. One result beat per sample beat, in order.
// wr_en/wr_index/wr_data: register writes (0 mean level, 1..5 constituents),
//          taken at any edge with wr_en high; write only while idle.
// A sample is taken only while the block is idle. The constituents
// run one per cycle through a four-stage pipe (angle multiply, sine table,
// amplitude multiply, accumulate), so one sample passes through the issue
// of the five constituents, the draining of the pipe, the hand-over of the
// result and the acceptance of the next sample. The next sample is accepted
// while a result still waits in the output register; if the receiver
// stalls, the block holds the following result until that register frees up.
// Reset: mean level 0.5 m, constituents zero, history cleared, no results.
module harmonic_tide_level_extrema (
  input  logic                              clk,
  input  logic                              rst,
  htle_in_if.sink                           samples,
  htle_out_if.source                        levels,
  input  logic                              wr_en,
  input  logic [htle_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [htle_pkg::CFG_W-1:0]        wr_data
);
  import htle_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  htle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  htle_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .sample_time    (samples.sample_time),
    .restart        (samples.restart),
    .out_valid      (levels.valid),
    .out_ready      (levels.ready),
    .tide_level     (levels.tide_level),
    .extremum_kind  (levels.extremum_kind),
    .extremum_time  (levels.extremum_time),
    .extremum_level (levels.extremum_level),
    .extremum_high  (levels.extremum_high)
  );

endmodule

FILE: design/htle_ctrl.sv
// Sequencer for the tide block: accepts a sample, issues one constituent
// per cycle into the datapath, then hands the result over. Uses htle_pkg.
module htle_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  htle_pkg::dp_status_t   status,
  output htle_pkg::ctrl_cmd_t    cmd
);
  import htle_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CALC) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (cnt == CNT_W'(CALC_LAST)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.issue    = 1'b0;
    cmd.term_idx = TERM_IDX_W'(cnt);
    cmd.finish   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_CALC: begin
        cmd.issue = (cnt < CNT_W'(ACT_TERMS));
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/htle_datapath.sv
// Datapath: configuration registers, four-stage constituent pipeline
// (angle multiply, sine lookup, amplitude multiply, accumulate), extremum
// history and the output register. Uses htle_pkg.
module htle_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  htle_pkg::ctrl_cmd_t                  cmd,
  output htle_pkg::dp_status_t                 status,
  input  logic                                 wr_en,
  input  logic [htle_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [htle_pkg::CFG_W-1:0]           wr_data,
  input  logic [31:0]                          sample_time,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   tide_level,
  output logic [1:0]                           extremum_kind,
  output logic [31:0]                          extremum_time,
  output logic signed [15:0]                   extremum_level,
  output logic                                 extremum_high
);
  import htle_pkg::*;

  // configuration
  logic signed [15:0] sea_mean;
  logic [CFG_W-1:0]   term_regs [TERM_REGS];

  // captured sample
  logic [31:0] t_reg;
  logic        restart_reg;

  // pipeline
  logic                      v1, v2, v3;
  logic [41:0]               angle_prod;
  logic [15:0]               phase1;
  logic signed [15:0]        amp1;
  logic [14:0]               sine_raw;
  logic                      neg2;
  logic signed [15:0]        amp2;
  logic signed [32:0]        amp_prod;
  logic signed [ACC_W-1:0]   acc;

  // history
  logic signed [15:0] older_level;
  logic signed [15:0] middle_level;
  logic [31:0]        middle_time;
  logic [1:0]         history_count;

  logic [CFG_W-1:0]          sel_term;
  logic [63:0]               mul_full;
  logic [31:0]               angle;
  logic [SINE_TABLE_BITS-1:0] tab_i;
  logic [ROM_ADDR_W-1:0]     rom_addr;
  logic signed [16:0]        sine_val;
  logic signed [33:0]        rounded;
  logic signed [ACC_W-1:0]   term_val;
  logic signed [15:0]        cur;
  logic signed [15:0]        eff_older;
  logic signed [15:0]        eff_middle;
  logic [1:0]                eff_count;
  logic [1:0]                kind;

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sea_mean <= MEAN_RESET;
      for (int k = 0; k < TERM_REGS; k++) begin
        term_regs[k] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index == REG_MEAN) begin
        sea_mean <= $signed(wr_data[15:0]);
      end else if (wr_index <= REG_IDX_W'(TERM_REGS)) begin
        term_regs[TERM_IDX_W'(wr_index - REG_TERM0)] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_reg       <= sample_time;
      restart_reg <= restart;
    end
  end

  // stage 1: angle product, keep the bits that survive the Q22.10 shift
  assign sel_term = term_regs[cmd.term_idx];
  assign mul_full = {32'b0, t_reg} * {32'b0, sel_term[47:16]};

  // stage 2: angle and quarter-wave address
  assign angle    = angle_prod[41:10] + {phase1, 16'b0};
  assign tab_i    = angle[29 -: SINE_TABLE_BITS];
  assign rom_addr = angle[30] ? ROM_ADDR_W'(TAB_N) - {1'b0, tab_i} : {1'b0, tab_i};

  // stage 3: sign of the half wave
  assign sine_val = neg2 ? -$signed({2'b0, sine_raw}) : $signed({2'b0, sine_raw});

  // stage 4: round to Q4.12, floor of (p + 2^14) / 2^15
  assign rounded  = (34'(amp_prod) + 34'sd16384) >>> 15;
  assign term_val = ACC_W'(rounded);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    angle_prod <= mul_full[41:0];
    phase1     <= sel_term[15:0];
    amp1       <= $signed(sel_term[63:48]);
    sine_raw   <= SINE_TAB[rom_addr];
    neg2       <= angle[31];
    amp2       <= amp1;
    amp_prod   <= amp2 * sine_val;
    if (cmd.start) begin
      acc <= ACC_W'(sea_mean);
    end else if (v3) begin
      acc <= acc + term_val;
    end
  end

  // saturate the finished sum and classify the middle sample
  always_comb begin
    if (acc > ACC_W'(32767)) begin
      cur = 16'sd32767;
    end else if (acc < -ACC_W'(32768)) begin
      cur = -16'sd32768;
    end else begin
      cur = acc[15:0];
    end
    eff_older  = restart_reg ? 16'sd0 : older_level;
    eff_middle = restart_reg ? 16'sd0 : middle_level;
    eff_count  = restart_reg ? 2'd0 : history_count;
    kind       = KIND_NONE;
    if (eff_count == 2'd2) begin
      if (eff_middle > eff_older && eff_middle > cur) begin
        kind = KIND_MAX;
      end else if (eff_middle < eff_older && eff_middle < cur) begin
        kind = KIND_MIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_count <= 2'd0;
      older_level   <= 16'sd0;
      middle_level  <= 16'sd0;
      middle_time   <= 32'd0;
    end else if (cmd.finish) begin
      older_level  <= eff_middle;
      middle_level <= cur;
      middle_time  <= t_reg;
      if (eff_count != 2'd2) begin
        history_count <= eff_count + 2'd1;
      end else begin
        history_count <= eff_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      tide_level    <= cur;
      extremum_kind <= kind;
      if (kind != KIND_NONE) begin
        extremum_time  <= middle_time;
        extremum_level <= eff_middle;
        extremum_high  <= (eff_middle > sea_mean);
      end else begin
        extremum_time  <= 32'd0;
        extremum_level <= 16'sd0;
        extremum_high  <= 1'b0;
      end
    end
  end

endmodule
